/* rtl/srrip_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srrip_pkg
// Shared types and constants of the SRRIP replacement-state block.
// ----------------------------------------------------------------------------
package srrip_pkg;

  localparam int RRPV_BITS = 2;
  localparam int NUM_WAYS  = 8;
  localparam int NUM_SETS  = 64;

  // Field widths of the transaction ports
  localparam int REQ_W = 2;
  localparam int SET_W = 6;
  localparam int WAY_W = 3;

  // Index widths into the storage
  localparam int WAY_AW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int SET_AW = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

  localparam logic [RRPV_BITS-1:0] RRPV_MAX = '1;

  // Register map: hit mode select (1 = hit clears the RRPV) at byte address 0
  localparam logic [2:0] ADDR_HIT_ZERO = 3'd0;

  typedef enum logic [REQ_W-1:0] {
    REQ_HIT   = 2'd0,
    REQ_FILL  = 2'd1,
    REQ_INVAL = 2'd2,
    REQ_QUERY = 2'd3
  } req_type_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // One set row: a valid bit and an RRPV per way
  typedef struct packed {
    logic [NUM_WAYS-1:0]                valid;
    logic [NUM_WAYS-1:0][RRPV_BITS-1:0] rrpv;
  } row_t;

  typedef struct packed {
    req_type_t         req_type;
    logic [SET_W-1:0]  set_index;
    logic [WAY_W-1:0]  way;
  } item_t;

  typedef struct packed {
    logic [WAY_W-1:0] victim_way;
    logic             victim_was_invalid;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [SET_AW-1:0] addr;
    row_t              row;
  } mem_wr_t;

endpackage : srrip_pkg
`default_nettype wire

/* rtl/srrip_row_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srrip_row_mem
// Set-row memory, registered read; rows never written read as zero.
// ----------------------------------------------------------------------------
module srrip_row_mem
  import srrip_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              rd_en,
  input  wire logic [SET_AW-1:0] rd_addr,
  output row_t                   rd_row,
  input  wire mem_wr_t           wr
);

  row_t                mem [NUM_SETS];
  logic [NUM_SETS-1:0] row_vld_r;
  row_t                rd_q_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.row;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // Per-row written flags stand in for clearing the array at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr.en) begin
        row_vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  assign rd_row = rd_vld_r ? rd_q_r : '0;

endmodule : srrip_row_mem
`default_nettype wire

/* rtl/srrip_update.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srrip_update
// Row modify logic: hit/fill/invalidate update and victim search with ageing.
// ----------------------------------------------------------------------------
module srrip_update
  import srrip_pkg::*;
(
  input  wire item_t   item,
  input  wire logic    set_ok,
  input  wire logic    hit_zero,
  input  wire row_t    row_in,
  output row_t         row_out,
  output logic         wr_en,
  output result_t      res
);

  logic [WAY_AW-1:0]    wsel;
  logic                 way_ok;
  logic                 any_inv;
  logic [WAY_W-1:0]     inv_way;
  logic [WAY_W-1:0]     best_way;
  logic [RRPV_BITS-1:0] best_val;
  logic [RRPV_BITS-1:0] diff;
  logic [RRPV_BITS:0]   sum  [NUM_WAYS];
  logic [NUM_WAYS-1:0][RRPV_BITS-1:0] aged;

  assign wsel   = item.way[WAY_AW-1:0];
  assign way_ok = set_ok && ({1'b0, item.way} < (WAY_W+1)'(NUM_WAYS));

  // Lowest invalid way
  always_comb begin
    any_inv = 1'b0;
    inv_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (!row_in.valid[w]) begin
        any_inv = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
  end

  // Lowest way holding the largest RRPV
  always_comb begin
    best_val = row_in.rrpv[0];
    best_way = '0;
    for (int w = 1; w < NUM_WAYS; w++) begin
      if (row_in.rrpv[w] > best_val) begin
        best_val = row_in.rrpv[w];
        best_way = WAY_W'(w);
      end
    end
  end

  assign diff = RRPV_MAX - best_val;

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      sum[w]  = {1'b0, row_in.rrpv[w]} + {1'b0, diff};
      aged[w] = (sum[w] > {1'b0, RRPV_MAX}) ? RRPV_MAX : sum[w][RRPV_BITS-1:0];
    end
  end

  always_comb begin
    row_out = row_in;
    wr_en   = 1'b0;
    res     = '0;
    unique case (item.req_type)
      REQ_HIT: begin
        if (way_ok) begin
          wr_en = 1'b1;
          if (hit_zero) begin
            row_out.rrpv[wsel] = '0;
          end else if (row_in.rrpv[wsel] != '0) begin
            row_out.rrpv[wsel] = row_in.rrpv[wsel] - 1'b1;
          end
        end
      end
      REQ_FILL: begin
        if (way_ok) begin
          wr_en               = 1'b1;
          row_out.rrpv[wsel]  = RRPV_MAX;
          row_out.valid[wsel] = 1'b1;
        end
      end
      REQ_INVAL: begin
        if (way_ok) begin
          wr_en               = 1'b1;
          row_out.valid[wsel] = 1'b0;
        end
      end
      REQ_QUERY: begin
        if (set_ok) begin
          if (any_inv) begin
            res.victim_way         = inv_way;
            res.victim_was_invalid = 1'b1;
          end else begin
            res.victim_way = best_way;
            wr_en          = 1'b1;
            row_out.rrpv   = aged;
          end
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

endmodule : srrip_update
`default_nettype wire

/* rtl/srrip_replacement_policy.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srrip_replacement_policy
// SRRIP replacement state: per-set RRPVs and valid bits, victim selection.
// ----------------------------------------------------------------------------
// Result: loaded into the output register as UPDATE completes; UPDATE holds
//   while the previous result is not yet taken. A new transaction is taken
//   only after the read-modify-write (read, then write back) of one set row.
// Reset: synchronous active-low; all rows read as all-invalid with RRPV 0
//   right after reset (per-row written flags, no clearing pass);
//   hit_zero resets to 1.
// ----------------------------------------------------------------------------
module srrip_replacement_policy
  import srrip_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // request channel
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [REQ_W-1:0] in_req_type,
  input  wire logic [SET_W-1:0] in_set_index,
  input  wire logic [WAY_W-1:0] in_way,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [WAY_W-1:0]      out_victim_way,
  output logic                  out_victim_was_invalid,
  // APB-style register port
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  state_t  state_r, state_nxt;
  item_t   item_r;
  logic    set_ok_r;
  logic    hit_zero_r;
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  logic    accept;
  logic    load_out;
  logic    rd_en;
  row_t    rd_row;
  row_t    upd_row;
  logic    upd_wr;
  result_t upd_res;
  mem_wr_t mem_wr;

  // ---------------------------------------------------------------------------
  // Register port. pready is tied high; writes land in the access phase.
  // Register map: word index taken from paddr[2]
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_zero_r <= 1'b1;
    end else if (psel && penable && pwrite && (paddr[2] == ADDR_HIT_ZERO[2])) begin
      hit_zero_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == ADDR_HIT_ZERO[2]) ? {31'd0, hit_zero_r} : 32'd0;

  // ---------------------------------------------------------------------------
  // Sequencer. IDLE takes a transaction and issues the row read; UPDATE sees
  // the row, writes it back and loads the result register. UPDATE holds while
  // the result register is still occupied; the read data stays put since no
  // new read is issued.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rd_en     = 1'b1;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign accept        = in_valid && in_ready;
  assign out_valid_nxt = load_out || (out_valid_r && !out_ready);

  // Captured request; sets beyond the array are flagged and ignored
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.req_type  <= req_type_t'(in_req_type);
      item_r.set_index <= in_set_index;
      item_r.way       <= in_way;
      set_ok_r         <= ({1'b0, in_set_index} < (SET_W+1)'(NUM_SETS));
    end
  end

  // ---------------------------------------------------------------------------
  // Row memory and modify logic
  // ---------------------------------------------------------------------------
  srrip_row_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (in_set_index[SET_AW-1:0]),
    .rd_row  (rd_row),
    .wr      (mem_wr)
  );

  srrip_update u_upd (
    .item     (item_r),
    .set_ok   (set_ok_r),
    .hit_zero (hit_zero_r),
    .row_in   (rd_row),
    .row_out  (upd_row),
    .wr_en    (upd_wr),
    .res      (upd_res)
  );

  // Write-back only on the cycle that leaves UPDATE, so a read of the same
  // row by the next transaction always sees the new contents.
  assign mem_wr.en   = load_out && upd_wr;
  assign mem_wr.addr = item_r.set_index[SET_AW-1:0];
  assign mem_wr.row  = upd_row;

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_res_r <= upd_res;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_victim_way         = out_res_r.victim_way;
  assign out_victim_was_invalid = out_res_r.victim_was_invalid;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_UPDATE))
    else $error("accepted transaction did not move to UPDATE");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && mem_wr.en))
    else $error("row read and write-back in the same cycle");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> (out_valid && (state_r == ST_IDLE)))
    else $error("finished update did not present a result");

  a_invalid_victim_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_victim_was_invalid) |->
      ({1'b0, out_victim_way} < (WAY_W+1)'(NUM_WAYS)))
    else $error("invalid-way victim outside the set");

endmodule : srrip_replacement_policy
`default_nettype wire

/* tb/srrip_replacement_policy_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// srrip_replacement_policy_test
// Self-checking bench for the SRRIP replacement-state block. A directed table
// covers the basics: empty sets, full sets at max, ageing, invalidates and a
// hit on an invalid way. Random traffic follows in both hit modes. Every
// result transaction is checked against a pinned table value or a shadow model
// of the per-set state, with random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module srrip_replacement_policy_test
  import srrip_pkg::*;
();

  localparam int DIR_ROWS      = 25;
  localparam int HOLD_CYCLES   = 150;     // long receiver hold-off
  localparam int SETTLE_CYCLES = 4;       // settle margin after the last result
  localparam int CYCLE_LIMIT   = 250000;  // watchdog limit

  // One directed row: request, plus a typed expectation when pinned is set
  typedef struct packed {
    req_type_t        req;
    logic [SET_W-1:0] set_idx;
    logic [WAY_W-1:0] way_idx;
    logic             pinned;
    logic [WAY_W-1:0] exp_way;
    logic             exp_invalid;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // empty sets right after reset: way 0 is the first invalid way
    '{REQ_QUERY, 6'd0,  3'd0, 1'b1, 3'd0, 1'b1},
    '{REQ_QUERY, 6'd63, 3'd7, 1'b1, 3'd0, 1'b1},
    // fill every way of set 5
    '{REQ_FILL,  6'd5,  3'd0, 1'b1, 3'd0, 1'b0},
    '{REQ_FILL,  6'd5,  3'd1, 1'b1, 3'd0, 1'b0},
    '{REQ_FILL,  6'd5,  3'd2, 1'b1, 3'd0, 1'b0},
    '{REQ_FILL,  6'd5,  3'd3, 1'b1, 3'd0, 1'b0},
    '{REQ_FILL,  6'd5,  3'd4, 1'b1, 3'd0, 1'b0},
    '{REQ_FILL,  6'd5,  3'd5, 1'b1, 3'd0, 1'b0},
    '{REQ_FILL,  6'd5,  3'd6, 1'b1, 3'd0, 1'b0},
    '{REQ_FILL,  6'd5,  3'd7, 1'b1, 3'd0, 1'b0},
    // all at max: lowest way wins, no ageing
    '{REQ_QUERY, 6'd5,  3'd0, 1'b1, 3'd0, 1'b0},
    // hit-priority mode: every hit drops the way to 0
    '{REQ_HIT,   6'd5,  3'd0, 1'b1, 3'd0, 1'b0},
    '{REQ_HIT,   6'd5,  3'd1, 1'b1, 3'd0, 1'b0},
    '{REQ_HIT,   6'd5,  3'd2, 1'b1, 3'd0, 1'b0},
    '{REQ_HIT,   6'd5,  3'd3, 1'b1, 3'd0, 1'b0},
    '{REQ_HIT,   6'd5,  3'd4, 1'b1, 3'd0, 1'b0},
    '{REQ_HIT,   6'd5,  3'd5, 1'b1, 3'd0, 1'b0},
    '{REQ_HIT,   6'd5,  3'd6, 1'b1, 3'd0, 1'b0},
    '{REQ_HIT,   6'd5,  3'd7, 1'b1, 3'd0, 1'b0},
    // all zero: way 0 wins and the whole set ages to max
    '{REQ_QUERY, 6'd5,  3'd0, 1'b1, 3'd0, 1'b0},
    '{REQ_QUERY, 6'd5,  3'd0, 1'b1, 3'd0, 1'b0},
    // invalid way beats any RRPV
    '{REQ_INVAL, 6'd5,  3'd6, 1'b1, 3'd0, 1'b0},
    '{REQ_QUERY, 6'd5,  3'd0, 1'b1, 3'd6, 1'b1},
    // hit on an invalid way leaves the valid bit alone
    '{REQ_HIT,   6'd63, 3'd7, 1'b0, 3'd0, 1'b0},
    '{REQ_QUERY, 6'd63, 3'd0, 1'b0, 3'd0, 1'b0}
  };

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [REQ_W-1:0] in_req_type;
  logic [SET_W-1:0] in_set_index;
  logic [WAY_W-1:0] in_way;
  logic             out_valid;
  logic             out_ready;
  logic [WAY_W-1:0] out_victim_way;
  logic             out_victim_was_invalid;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [2:0]       paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  // Typed expectation rides along with the payload, driven on the same edge
  logic             typed_en;
  result_t          typed_result;

  // Pressure / idling controls, driven by the stimulus process
  bit               calm        = 1'b0;  // no idling on either side
  int               hold_ticket = 0;     // bump to request one long hold-off

  // Shadow of the block's state and register
  logic [RRPV_BITS-1:0] rrpv_shadow  [NUM_SETS][NUM_WAYS];
  logic                 valid_shadow [NUM_SETS][NUM_WAYS];
  logic                 hit_zero_shadow;

  result_t pending_victims [$];  // expected result transactions, oldest first

  int error_count     = 0;
  int cycle_count     = 0;
  int items_sent      = 0;
  int query_count     = 0;
  int invalid_victims = 0;
  int aged_sets       = 0;

  srrip_replacement_policy i_dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_req_type            (in_req_type),
    .in_set_index           (in_set_index),
    .in_way                 (in_way),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_victim_way         (out_victim_way),
    .out_victim_was_invalid (out_victim_was_invalid),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Shadow model: apply one request, return the result it should produce
  // --------------------------------------------------------------------------
  function automatic result_t apply_policy_request(req_type_t rt, logic [SET_W-1:0] s,
                                                   logic [WAY_W-1:0] w);
    result_t              r;
    logic [RRPV_BITS-1:0] top;
    int                   pick;
    int                   gap;
    int                   sum;
    int                   i;
    r = '0;
    case (rt)
      REQ_HIT: begin
        if (hit_zero_shadow)
          rrpv_shadow[s][w] = '0;
        else if (rrpv_shadow[s][w] != '0)
          rrpv_shadow[s][w] = rrpv_shadow[s][w] - 1'b1;
      end
      REQ_FILL: begin
        rrpv_shadow[s][w]  = RRPV_MAX;
        valid_shadow[s][w] = 1'b1;
      end
      REQ_INVAL: begin
        valid_shadow[s][w] = 1'b0;
      end
      REQ_QUERY: begin
        query_count++;
        // lowest invalid way wins outright, no ageing
        pick = -1;
        for (i = NUM_WAYS - 1; i >= 0; i--)
          if (!valid_shadow[s][i]) pick = i;
        if (pick >= 0) begin
          r.victim_way         = WAY_W'(pick);
          r.victim_was_invalid = 1'b1;
          invalid_victims++;
        end else begin
          // lowest way holding the largest RRPV
          pick = 0;
          top  = rrpv_shadow[s][0];
          for (i = 1; i < NUM_WAYS; i++)
            if (rrpv_shadow[s][i] > top) begin
              pick = i;
              top  = rrpv_shadow[s][i];
            end
          // age the set so the victim lands on max, saturating
          gap = int'(RRPV_MAX) - int'(top);
          if (gap > 0) aged_sets++;
          for (i = 0; i < NUM_WAYS; i++) begin
            sum = int'(rrpv_shadow[s][i]) + gap;
            rrpv_shadow[s][i] = (sum > int'(RRPV_MAX)) ? RRPV_MAX : RRPV_BITS'(sum);
          end
          r.victim_way = WAY_W'(pick);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint exp);
    error_count++;
    $display("MISMATCH [cycle %0d] %s: got %0d, expected %0d", cycle_count, what, got, exp);
  endtask

  // --------------------------------------------------------------------------
  // Monitor: results are checked before the same-edge input is predicted,
  // since a request can't produce its result on its own acceptance edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_victims.size() == 0) begin
          flag_mismatch("result transaction with nothing pending", out_victim_way, 0);
        end else begin
          want = pending_victims.pop_front();
          if (out_victim_way !== want.victim_way)
            flag_mismatch("victim_way", out_victim_way, want.victim_way);
          if (out_victim_was_invalid !== want.victim_was_invalid)
            flag_mismatch("victim_was_invalid", out_victim_was_invalid,
                          want.victim_was_invalid);
        end
      end
      if (in_valid && in_ready) begin
        want = apply_policy_request(req_type_t'(in_req_type), in_set_index, in_way);
        if (typed_en) want = typed_result;  // directed row: hand-written value rules
        pending_victims.push_back(want);
      end
      // register writes happen only while idle, so ordering vs. traffic is moot
      if (psel && penable && pwrite && pready && paddr == ADDR_HIT_ZERO)
        hit_zero_shadow = pwdata[0];
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, one long hold-off per ticket, none when calm
  // --------------------------------------------------------------------------
  initial begin : receiver
    int served;
    served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ticket != served) begin
        served = hold_ticket;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers. send_request returns on the acceptance edge with valid still
  // high unless it adds a random idle gap (never when calm); otherwise back-to-back requests do not drop valid.
  // --------------------------------------------------------------------------
  task automatic sender_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_request(req_type_t rt, logic [SET_W-1:0] s, logic [WAY_W-1:0] w,
                              logic pinned, result_t pres);
    in_valid     <= 1'b1;
    in_req_type  <= rt;
    in_set_index <= s;
    in_way       <= w;
    typed_en     <= pinned;
    typed_result <= pres;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (!calm && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 10));
  endtask

  // Stop sending and wait out every pending result
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_victims.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic read_hit_zero();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_HIT_ZERO;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'd0, hit_zero_shadow})
      flag_mismatch("hit_zero readback", prdata, hit_zero_shadow);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Block must be idle here
  task automatic set_hit_zero(logic hp);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_HIT_ZERO;
    pwdata  <= {31'd0, hp};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    read_hit_zero();
  endtask

  // Random traffic. Most requests go to a few hot sets so they fill up and
  // the ageing path gets real exercise; whole-set fill sequences are mixed in.
  task automatic random_phase(int count, bit pause_mid);
    logic [SET_W-1:0] hot [4];
    logic [SET_W-1:0] s;
    req_type_t        rt;
    int               sent;
    int               k;
    int               pick;
    bit               paused;
    for (k = 0; k < 4; k++) hot[k] = SET_W'($urandom_range(0, NUM_SETS - 1));
    sent   = 0;
    paused = 1'b0;
    while (sent < count) begin
      // sender pause: let the block drain completely mid-phase
      if (pause_mid && !paused && sent >= count / 2) begin
        paused = 1'b1;
        wait_idle();
      end
      s = hot[$urandom_range(0, 3)];
      if ($urandom_range(0, 6) == 0) begin
        for (k = 0; k < NUM_WAYS; k++)
          send_request(REQ_FILL, s, WAY_W'(k), 1'b0, '0);
        sent += NUM_WAYS;
      end else begin
        if ($urandom_range(0, 3) == 0) s = SET_W'($urandom_range(0, NUM_SETS - 1));
        pick = $urandom_range(0, 19);
        if (pick < 7)       rt = REQ_HIT;
        else if (pick < 12) rt = REQ_QUERY;
        else if (pick < 17) rt = REQ_FILL;
        else                rt = REQ_INVAL;
        send_request(rt, s, WAY_W'($urandom_range(0, NUM_WAYS - 1)), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Watchdog
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    result_t pres;
    int      r;
    int      s;
    int      w;

    // every input known from time 0
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_req_type  <= REQ_HIT;
    in_set_index <= '0;
    in_way       <= '0;
    typed_en     <= 1'b0;
    typed_result <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;

    // shadow reset state
    hit_zero_shadow = 1'b1;
    for (s = 0; s < NUM_SETS; s++)
      for (w = 0; w < NUM_WAYS; w++) begin
        rrpv_shadow[s][w]  = '0;
        valid_shadow[s][w] = 1'b0;
      end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of the hit mode register
    read_hit_zero();

    // directed table, hit-priority mode from reset
    for (r = 0; r < DIR_ROWS; r++) begin
      pres.victim_way         = DIR_TABLE[r].exp_way;
      pres.victim_was_invalid = DIR_TABLE[r].exp_invalid;
      send_request(DIR_TABLE[r].req, DIR_TABLE[r].set_idx, DIR_TABLE[r].way_idx,
                   DIR_TABLE[r].pinned, pres);
    end
    wait_idle();

    // frequency mode, with a long output hold-off so the block backs up
    set_hit_zero(1'b0);
    hold_ticket <= hold_ticket + 1;
    random_phase(220, 1'b0);
    wait_idle();

    // hit-priority mode, with a full drain halfway through
    set_hit_zero(1'b1);
    random_phase(220, 1'b1);
    wait_idle();

    set_hit_zero(1'b0);
    random_phase(200, 1'b0);
    wait_idle();

    // last stretch at full rate, no idling anywhere
    set_hit_zero(1'b1);
    calm <= 1'b1;
    random_phase(210, 1'b0);
    wait_idle();

    $display("Covered %0d requests in both hit modes: %0d victim queries, %0d picked an",
             items_sent, query_count, invalid_victims);
    $display("invalid way, %0d aged a full set; stalls, hold-off and drain included.",
             aged_sets);
    if (error_count == 0 && pending_victims.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
